FILE: sv/lci_pkg.sv
// ----------------------------------------------------------------------------
// lci_pkg
// shared widths and payload types for the ray / circle intersection block
// ----------------------------------------------------------------------------
package lci_pkg;

  localparam int COORD_W  = 32;
  localparam int RADIUS_W = 31;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [RADIUS_W-1:0]       radius_t;

endpackage

FILE: sv/lci_in_if.sv
// ----------------------------------------------------------------------------
// lci_in_if
// query channel: ray start, second point, circle center and radius
// ----------------------------------------------------------------------------
interface lci_in_if;
  import lci_pkg::*;

  logic    valid;
  logic    ready;
  coord_t  start_x;
  coord_t  start_y;
  coord_t  toward_x;
  coord_t  toward_y;
  coord_t  center_x;
  coord_t  center_y;
  radius_t radius;

  modport source (
    output valid, start_x, start_y, toward_x, toward_y, center_x, center_y, radius,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, toward_x, toward_y, center_x, center_y, radius,
    output ready
  );
endinterface

FILE: sv/lci_out_if.sv
// ----------------------------------------------------------------------------
// lci_out_if
// result channel: hit flags, both distances and both contact points
// ----------------------------------------------------------------------------
interface lci_out_if;
  import lci_pkg::*;

  logic   valid;
  logic   ready;
  logic   hit;
  logic   degenerate;
  coord_t dist_far;
  coord_t dist_near;
  coord_t contact_far_x;
  coord_t contact_far_y;
  coord_t contact_near_x;
  coord_t contact_near_y;

  modport source (
    output valid, hit, degenerate, dist_far, dist_near,
           contact_far_x, contact_far_y, contact_near_x, contact_near_y,
    input  ready
  );

  modport sink (
    input  valid, hit, degenerate, dist_far, dist_near,
           contact_far_x, contact_far_y, contact_near_x, contact_near_y,
    output ready
  );
endinterface

FILE: sv/lci_isqrt.sv
// ----------------------------------------------------------------------------
// lci_isqrt
// pipelined integer square root, floor, a few digit steps per stage
// ----------------------------------------------------------------------------
module lci_isqrt #(
  parameter int W     = 64,
  parameter int STEPS = 2,
  parameter int SW    = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [W-1:0]    n_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [W/2-1:0]  root_o,
  output logic [SW-1:0]   side_o
);
  localparam int NIT = W / 2;
  localparam int NST = (NIT + STEPS - 1) / STEPS;

  logic [W-1:0]  n_q    [NST];
  logic [W-1:0]  r_q    [NST];
  logic [SW-1:0] side_q [NST];
  logic          valid_q[NST];

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [W-1:0]  n_in, r_in, n_v, r_v, b_v;
    logic [SW-1:0] side_in;
    logic          valid_in;

    if (s == 0) begin : g_first
      assign n_in     = n_i;
      assign r_in     = '0;
      assign side_in  = side_i;
      assign valid_in = valid_i;
    end else begin : g_next
      assign n_in     = n_q[s-1];
      assign r_in     = r_q[s-1];
      assign side_in  = side_q[s-1];
      assign valid_in = valid_q[s-1];
    end

    always_comb begin
      n_v = n_in;
      r_v = r_in;
      b_v = '0;
      for (int j = 0; j < STEPS; j++) begin
        if (s * STEPS + j < NIT) begin
          b_v = W'(1) << (W - 2 - 2 * (s * STEPS + j));
          if (n_v >= r_v + b_v) begin
            n_v = n_v - (r_v + b_v);
            r_v = (r_v >> 1) + b_v;
          end else begin
            r_v = r_v >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s]    <= n_v;
        r_q[s]    <= r_v;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[NST-1];
  assign root_o  = r_q[NST-1][W/2-1:0];
  assign side_o  = side_q[NST-1];
endmodule

FILE: sv/lci_div.sv
// ----------------------------------------------------------------------------
// lci_div
// pipelined restoring divider, two dividends over one shared divisor
// ----------------------------------------------------------------------------
module lci_div #(
  parameter int NW    = 49,
  parameter int DW    = 32,
  parameter int QB    = 17,
  parameter int STEPS = 2,
  parameter int SW    = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [NW-1:0]  num_a_i,
  input  logic [NW-1:0]  num_b_i,
  input  logic [DW-1:0]  den_i,
  input  logic [SW-1:0]  side_i,
  output logic           valid_o,
  output logic [QB-1:0]  quo_a_o,
  output logic [QB-1:0]  quo_b_o,
  output logic [SW-1:0]  side_o
);
  localparam int NST = (QB + STEPS - 1) / STEPS;

  logic [DW-1:0] rem_a_q[NST];
  logic [DW-1:0] rem_b_q[NST];
  logic [QB-1:0] low_a_q[NST];
  logic [QB-1:0] low_b_q[NST];
  logic [DW-1:0] den_q  [NST];
  logic [SW-1:0] side_q [NST];
  logic          valid_q[NST];

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [DW-1:0] rem_a_in, rem_b_in, den_in, rem_a_v, rem_b_v;
    logic [QB-1:0] low_a_in, low_b_in, low_a_v, low_b_v;
    logic [DW:0]   t_a, t_b;
    logic [SW-1:0] side_in;
    logic          valid_in;

    if (s == 0) begin : g_first
      assign rem_a_in = DW'(num_a_i >> QB);
      assign rem_b_in = DW'(num_b_i >> QB);
      assign low_a_in = num_a_i[QB-1:0];
      assign low_b_in = num_b_i[QB-1:0];
      assign den_in   = den_i;
      assign side_in  = side_i;
      assign valid_in = valid_i;
    end else begin : g_next
      assign rem_a_in = rem_a_q[s-1];
      assign rem_b_in = rem_b_q[s-1];
      assign low_a_in = low_a_q[s-1];
      assign low_b_in = low_b_q[s-1];
      assign den_in   = den_q[s-1];
      assign side_in  = side_q[s-1];
      assign valid_in = valid_q[s-1];
    end

    always_comb begin
      rem_a_v = rem_a_in;
      rem_b_v = rem_b_in;
      low_a_v = low_a_in;
      low_b_v = low_b_in;
      t_a     = '0;
      t_b     = '0;
      for (int j = 0; j < STEPS; j++) begin
        if (s * STEPS + j < QB) begin
          t_a = {rem_a_v, low_a_v[QB-1]};
          t_b = {rem_b_v, low_b_v[QB-1]};
          if (t_a >= {1'b0, den_in}) begin
            rem_a_v = DW'(t_a - {1'b0, den_in});
            low_a_v = {low_a_v[QB-2:0], 1'b1};
          end else begin
            rem_a_v = t_a[DW-1:0];
            low_a_v = {low_a_v[QB-2:0], 1'b0};
          end
          if (t_b >= {1'b0, den_in}) begin
            rem_b_v = DW'(t_b - {1'b0, den_in});
            low_b_v = {low_b_v[QB-2:0], 1'b1};
          end else begin
            rem_b_v = t_b[DW-1:0];
            low_b_v = {low_b_v[QB-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_a_q[s] <= rem_a_v;
        rem_b_q[s] <= rem_b_v;
        low_a_q[s] <= low_a_v;
        low_b_q[s] <= low_b_v;
        den_q[s]   <= den_in;
        side_q[s]  <= side_in;
      end
    end
  end

  assign valid_o = valid_q[NST-1];
  assign quo_a_o = low_a_q[NST-1];
  assign quo_b_o = low_b_q[NST-1];
  assign side_o  = side_q[NST-1];
endmodule

FILE: sv/line_circle_intersection.sv
// ----------------------------------------------------------------------------
// line_circle_intersection
// fixed-point ray / circle intersection, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   in_i carries one query word: ray start, a second point on the ray and a
//   circle (center, radius), in fixed point with FRAC_BITS fraction bits
//   (coordinates signed, radius unsigned). out_o returns one result word
//   per query, in order: hit and degenerate flags, far and near distance
//   along the unit direction, and the two contact points (zero unless hit)
//   depth: the pipeline is dominated by two 16-stage square roots (two root
//   digits per stage) and the restoring divider that normalizes the direction
//   throughput: one word per cycle while not stalled, queries enter back to back
//   stall: the whole pipeline advances on one enable; while a result waits
//   in the output register and out_o.ready is low, in_i.ready drops and every
//   stage holds, so nothing is lost or repeated
//   reset: rst_ni clears all stage valid bits and the output valid; payload
//   registers are not reset
// ----------------------------------------------------------------------------
module line_circle_intersection #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  lci_in_if.sink    in_i,
  lci_out_if.source out_o
);
  import lci_pkg::*;

  // width plan
  localparam int MW    = 31;                // direction magnitude after prescale
  localparam int QB    = FRAC_BITS + 1;     // unit component magnitude bits
  localparam int DW    = 32;                // length width
  localparam int NW    = DW + QB;           // divider dividend width
  localparam int UW    = FRAC_BITS + 2;     // signed unit component
  localparam int VW    = 33;                // start - center
  localparam int PW    = UW + VW;           // unit times offset
  localparam int DOTW  = PW + 1;
  localparam int HW    = 36;                // half-b and cross term
  localparam int SQW   = 64;                // square root operand width
  localparam int SW    = 37;                // distances before saturation
  localparam int CPW   = UW + SW;           // unit times distance
  localparam int SIDE1 = 3 + 2 * COORD_W + 2 * VW + RADIUS_W;
  localparam int SIDE0 = 2 * MW + SIDE1;
  localparam int SIDE2 = HW + 2 + 2 * COORD_W + 2 * UW;
  localparam logic signed [UW-1:0] UNIT = UW'(1) << FRAC_BITS;

  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x);
    logic [63:0] m;
    m = x[63] ? 64'(-x) : 64'(x);
    m = (m + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return x[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return x[31:0];
    end
  endfunction

  // global advance enable
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // stage a: differences, prescale, degenerate check
  logic signed [VW-1:0] dx_d, dy_d, vx_d, vy_d;
  logic [VW-1:0]        ax_d, ay_d;
  logic                 big_d;
  logic                 valid_a_q, deg_a_q, sgnx_a_q, sgny_a_q;
  logic [MW-1:0]        mx_a_q, my_a_q;
  coord_t               sx_a_q, sy_a_q;
  logic signed [VW-1:0] vx_a_q, vy_a_q;
  radius_t              r_a_q;

  always_comb begin
    dx_d  = VW'(in_i.toward_x) - VW'(in_i.start_x);
    dy_d  = VW'(in_i.toward_y) - VW'(in_i.start_y);
    vx_d  = VW'(in_i.start_x) - VW'(in_i.center_x);
    vy_d  = VW'(in_i.start_y) - VW'(in_i.center_y);
    ax_d  = dx_d[VW-1] ? VW'(-dx_d) : VW'(dx_d);
    ay_d  = dy_d[VW-1] ? VW'(-dy_d) : VW'(dy_d);
    // keep both magnitudes below 2^31 so the squares fit
    big_d = (ax_d[VW-1:MW] != '0) || (ay_d[VW-1:MW] != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (en) begin
      valid_a_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_a_q  <= (dx_d == '0) && (dy_d == '0);
      sgnx_a_q <= dx_d[VW-1];
      sgny_a_q <= dy_d[VW-1];
      mx_a_q   <= big_d ? ax_d[MW:1] : ax_d[MW-1:0];
      my_a_q   <= big_d ? ay_d[MW:1] : ay_d[MW-1:0];
      sx_a_q   <= in_i.start_x;
      sy_a_q   <= in_i.start_y;
      vx_a_q   <= vx_d;
      vy_a_q   <= vy_d;
      r_a_q    <= in_i.radius;
    end
  end

  // stage b: squares of the direction magnitudes
  logic                 valid_b_q;
  logic [2*MW-1:0]      sqx_b_q, sqy_b_q;
  logic [MW-1:0]        mx_b_q, my_b_q;
  logic [SIDE1-1:0]     side_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else if (en) begin
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_b_q  <= mx_a_q * mx_a_q;
      sqy_b_q  <= my_a_q * my_a_q;
      mx_b_q   <= mx_a_q;
      my_b_q   <= my_a_q;
      side_b_q <= {sgnx_a_q, sgny_a_q, deg_a_q, sx_a_q, sy_a_q, vx_a_q, vy_a_q, r_a_q};
    end
  end

  // stage c: squared length
  logic                 valid_c_q;
  logic [2*MW:0]        sum_c_q;
  logic [SIDE0-1:0]     side_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c_q <= 1'b0;
    end else if (en) begin
      valid_c_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_c_q  <= {1'b0, sqx_b_q} + {1'b0, sqy_b_q};
      side_c_q <= {mx_b_q, my_b_q, side_b_q};
    end
  end

  // length = floor(sqrt(mx^2 + my^2)) of the prescaled magnitudes
  logic             valid_l;
  logic [DW-1:0]    len_l;
  logic [SIDE0-1:0] side_l;

  lci_isqrt #(.W(SQW), .STEPS(2), .SW(SIDE0)) u_len_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_c_q),
    .n_i     (SQW'(sum_c_q)),
    .side_i  (side_c_q),
    .valid_o (valid_l),
    .root_o  (len_l),
    .side_o  (side_l)
  );

  // stage d: rounded dividends for the unit direction
  logic [DW-1:0]    lenc_d;
  logic [MW-1:0]    mx_l, my_l;
  logic [SIDE1-1:0] side1_l;
  logic             valid_d_q;
  logic [NW-1:0]    nx_d_q, ny_d_q;
  logic [DW-1:0]    len_d_q;
  logic [SIDE1-1:0] side_d_q;

  assign {mx_l, my_l, side1_l} = side_l;
  assign lenc_d = (len_l == '0) ? DW'(1) : len_l;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_d_q <= 1'b0;
    end else if (en) begin
      valid_d_q <= valid_l;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_d_q   <= (NW'(mx_l) << FRAC_BITS) + NW'(lenc_d >> 1);
      ny_d_q   <= (NW'(my_l) << FRAC_BITS) + NW'(lenc_d >> 1);
      len_d_q  <= lenc_d;
      side_d_q <= side1_l;
    end
  end

  // unit direction magnitudes
  logic             valid_u;
  logic [QB-1:0]    qx_u, qy_u;
  logic [SIDE1-1:0] side_u;

  lci_div #(.NW(NW), .DW(DW), .QB(QB), .STEPS(2), .SW(SIDE1)) u_norm_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_d_q),
    .num_a_i (nx_d_q),
    .num_b_i (ny_d_q),
    .den_i   (len_d_q),
    .side_i  (side_d_q),
    .valid_o (valid_u),
    .quo_a_o (qx_u),
    .quo_b_o (qy_u),
    .side_o  (side_u)
  );

  // stage e: signed unit vector and its products with start - center
  logic                 sgnx_u, sgny_u, deg_u;
  coord_t               sx_u, sy_u;
  logic signed [VW-1:0] vx_u, vy_u;
  radius_t              r_u;
  logic signed [UW-1:0] ux_d, uy_d;
  logic                 valid_e_q, deg_e_q;
  logic signed [UW-1:0] ux_e_q, uy_e_q;
  logic signed [PW-1:0] pxx_e_q, pyy_e_q, pxy_e_q, pyx_e_q;
  coord_t               sx_e_q, sy_e_q;
  radius_t              r_e_q;

  assign {sgnx_u, sgny_u, deg_u, sx_u, sy_u, vx_u, vy_u, r_u} = side_u;
  assign ux_d = sgnx_u ? -$signed(UW'(qx_u)) : $signed(UW'(qx_u));
  assign uy_d = sgny_u ? -$signed(UW'(qy_u)) : $signed(UW'(qy_u));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_e_q <= 1'b0;
    end else if (en) begin
      valid_e_q <= valid_u;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_e_q <= deg_u;
      ux_e_q  <= ux_d;
      uy_e_q  <= uy_d;
      pxx_e_q <= PW'(ux_d) * PW'(vx_u);
      pyy_e_q <= PW'(uy_d) * PW'(vy_u);
      pxy_e_q <= PW'(ux_d) * PW'(vy_u);
      pyx_e_q <= PW'(uy_d) * PW'(vx_u);
      sx_e_q  <= sx_u;
      sy_e_q  <= sy_u;
      r_e_q   <= r_u;
    end
  end

  // stage f: half of b (dot) and perpendicular offset (cross)
  logic signed [DOTW-1:0] dot_d, crs_d;
  logic                   valid_f_q, deg_f_q;
  logic signed [HW-1:0]   h_f_q, p_f_q;
  logic signed [UW-1:0]   ux_f_q, uy_f_q;
  coord_t                 sx_f_q, sy_f_q;
  radius_t                r_f_q;

  assign dot_d = DOTW'(pxx_e_q) + DOTW'(pyy_e_q);
  assign crs_d = DOTW'(pxy_e_q) - DOTW'(pyx_e_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_f_q <= 1'b0;
    end else if (en) begin
      valid_f_q <= valid_e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_f_q <= deg_e_q;
      h_f_q   <= HW'(rnd_shift(64'(dot_d)));
      p_f_q   <= HW'(rnd_shift(64'(crs_d)));
      ux_f_q  <= ux_e_q;
      uy_f_q  <= uy_e_q;
      sx_f_q  <= sx_e_q;
      sy_f_q  <= sy_e_q;
      r_f_q   <= r_e_q;
    end
  end

  // stage g: miss test and squares for the discriminant
  logic [HW-1:0]          pm_d;
  logic                   valid_g_q, deg_g_q, miss_g_q;
  logic [2*RADIUS_W-1:0]  rr_g_q, pp_g_q;
  logic signed [HW-1:0]   h_g_q;
  logic signed [UW-1:0]   ux_g_q, uy_g_q;
  coord_t                 sx_g_q, sy_g_q;

  assign pm_d = p_f_q[HW-1] ? HW'(-p_f_q) : HW'(p_f_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_g_q <= 1'b0;
    end else if (en) begin
      valid_g_q <= valid_f_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_g_q  <= deg_f_q;
      miss_g_q <= pm_d > HW'(r_f_q);
      rr_g_q   <= r_f_q * r_f_q;
      pp_g_q   <= pm_d[RADIUS_W-1:0] * pm_d[RADIUS_W-1:0];
      h_g_q    <= h_f_q;
      ux_g_q   <= ux_f_q;
      uy_g_q   <= uy_f_q;
      sx_g_q   <= sx_f_q;
      sy_g_q   <= sy_f_q;
    end
  end

  // stage h: quarter discriminant radius^2 - p^2
  logic                  valid_h_q;
  logic [2*RADIUS_W-1:0] disc_h_q;
  logic [SIDE2-1:0]      side_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_h_q <= 1'b0;
    end else if (en) begin
      valid_h_q <= valid_g_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      disc_h_q <= rr_g_q - pp_g_q;
      side_h_q <= {h_g_q, miss_g_q, deg_g_q, sx_g_q, sy_g_q, ux_g_q, uy_g_q};
    end
  end

  // half chord length
  logic              valid_s;
  logic [SQW/2-1:0]  q_s;
  logic [SIDE2-1:0]  side_s;

  lci_isqrt #(.W(SQW), .STEPS(2), .SW(SIDE2)) u_chord_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_h_q),
    .n_i     (SQW'(disc_h_q)),
    .side_i  (side_h_q),
    .valid_o (valid_s),
    .root_o  (q_s),
    .side_o  (side_s)
  );

  // stage i: both roots
  logic signed [HW-1:0] h_s;
  logic                 miss_s, deg_s;
  coord_t               sx_s, sy_s;
  logic signed [UW-1:0] ux_s, uy_s;
  logic signed [SW-1:0] s0_d, s1_d;
  logic                 valid_i_q, deg_i_q, miss_i_q, hit_i_q;
  logic signed [SW-1:0] s0_i_q, s1_i_q;
  logic signed [UW-1:0] ux_i_q, uy_i_q;
  coord_t               sx_i_q, sy_i_q;

  assign {h_s, miss_s, deg_s, sx_s, sy_s, ux_s, uy_s} = side_s;
  assign s0_d = -SW'(h_s) + $signed(SW'(q_s));
  assign s1_d = -SW'(h_s) - $signed(SW'(q_s));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i_q <= 1'b0;
    end else if (en) begin
      valid_i_q <= valid_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_i_q  <= deg_s;
      miss_i_q <= miss_s;
      hit_i_q  <= !deg_s && !miss_s && !s0_d[SW-1];
      s0_i_q   <= s0_d;
      s1_i_q   <= s1_d;
      ux_i_q   <= ux_s;
      uy_i_q   <= uy_s;
      sx_i_q   <= sx_s;
      sy_i_q   <= sy_s;
    end
  end

  // stage j: offsets along the ray for both contacts
  logic                  valid_j_q, deg_j_q, miss_j_q, hit_j_q;
  logic signed [CPW-1:0] ofx0_j_q, ofy0_j_q, ofx1_j_q, ofy1_j_q;
  logic signed [SW-1:0]  s0_j_q, s1_j_q;
  coord_t                sx_j_q, sy_j_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_j_q <= 1'b0;
    end else if (en) begin
      valid_j_q <= valid_i_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_j_q  <= deg_i_q;
      miss_j_q <= miss_i_q;
      hit_j_q  <= hit_i_q;
      ofx0_j_q <= CPW'(ux_i_q) * CPW'(s0_i_q);
      ofy0_j_q <= CPW'(uy_i_q) * CPW'(s0_i_q);
      ofx1_j_q <= CPW'(ux_i_q) * CPW'(s1_i_q);
      ofy1_j_q <= CPW'(uy_i_q) * CPW'(s1_i_q);
      s0_j_q   <= s0_i_q;
      s1_j_q   <= s1_i_q;
      sx_j_q   <= sx_i_q;
      sy_j_q   <= sy_i_q;
    end
  end

  // stage k: output register, saturation and zeroing
  logic   zero_dist;
  coord_t dfar_d, dnear_d, cfx_d, cfy_d, cnx_d, cny_d;
  logic   hit_q, deg_q;
  coord_t dfar_q, dnear_q, cfx_q, cfy_q, cnx_q, cny_q;

  always_comb begin
    zero_dist = deg_j_q || miss_j_q;
    dfar_d    = zero_dist ? '0 : sat32(64'(s0_j_q));
    dnear_d   = zero_dist ? '0 : sat32(64'(s1_j_q));
    cfx_d     = '0;
    cfy_d     = '0;
    cnx_d     = '0;
    cny_d     = '0;
    if (hit_j_q) begin
      cfx_d = sat32(64'(sx_j_q) + rnd_shift(64'(ofx0_j_q)));
      cfy_d = sat32(64'(sy_j_q) + rnd_shift(64'(ofy0_j_q)));
      cnx_d = sat32(64'(sx_j_q) + rnd_shift(64'(ofx1_j_q)));
      cny_d = sat32(64'(sy_j_q) + rnd_shift(64'(ofy1_j_q)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_j_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q   <= hit_j_q;
      deg_q   <= deg_j_q;
      dfar_q  <= dfar_d;
      dnear_q <= dnear_d;
      cfx_q   <= cfx_d;
      cfy_q   <= cfy_d;
      cnx_q   <= cnx_d;
      cny_q   <= cny_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.hit            = hit_q;
  assign out_o.degenerate     = deg_q;
  assign out_o.dist_far       = dfar_q;
  assign out_o.dist_near      = dnear_q;
  assign out_o.contact_far_x  = cfx_q;
  assign out_o.contact_far_y  = cfy_q;
  assign out_o.contact_near_x = cnx_q;
  assign out_o.contact_near_y = cny_q;

  // checks

  // a degenerate ray never reports a hit
  a_deg_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(deg_q && hit_q))
    else $error("degenerate result flagged as hit");

  // a hit always has a non-negative far distance
  a_hit_far_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && hit_q) |-> !dfar_q[31])
    else $error("hit with negative far distance");

  // far root is never below near root
  a_root_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($signed(dfar_q) >= $signed(dnear_q)))
    else $error("far distance below near distance");

  // the normalized direction stays within one unit per component
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_e_q && !deg_e_q) |-> (ux_e_q <= UNIT && ux_e_q >= -UNIT &&
                                 uy_e_q <= UNIT && uy_e_q >= -UNIT))
    else $error("unit direction out of range");

  // a stalled pipeline keeps its items in place
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(valid_a_q) && $stable(valid_j_q)))
    else $error("pipeline moved during stall");

endmodule
